/* src/ckm_pkg.sv */
// ----------------------------------------------------------------------------
// ckm_pkg
// Shared constants and types for the chroma key mask pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ckm_pkg;

   // BT.601 chroma coefficients, Q16
   localparam int CB_R_Q16 = 11058;
   localparam int CB_G_Q16 = 21710;
   localparam int CB_B_Q16 = 32768;
   localparam int CR_R_Q16 = 32768;
   localparam int CR_G_Q16 = 27439;
   localparam int CR_B_Q16 = 5329;
   localparam int CHROMA_OFS_Q16 = 128 * 65536;
   localparam int HALF_Q16 = 32768;

   // widths
   localparam int SQ_W   = 18;   // dcb^2 + dcr^2
   localparam int RAD_W  = 34;   // radicand, SQ << 16
   localparam int DIST_W = 17;   // distance, 8 fraction bits
   localparam int NUM_W  = 25;   // 255 * (d - lo)
   localparam int QUO_W  = 8;

   localparam int SQRT_CELLS = RAD_W / 2;   // one result bit per cell
   localparam int DIV_CELLS  = QUO_W;

   // register reset values
   localparam logic [7:0] KEY_CB_RST    = 8'd128;
   localparam logic [7:0] KEY_CR_RST    = 8'd128;
   localparam logic [8:0] TOL_INNER_RST = 9'd30;
   localparam logic [8:0] TOL_OUTER_RST = 9'd200;

   // register indexes
   localparam logic [1:0] REG_KEY_CB    = 2'd0;
   localparam logic [1:0] REG_KEY_CR    = 2'd1;
   localparam logic [1:0] REG_TOL_INNER = 2'd2;
   localparam logic [1:0] REG_TOL_OUTER = 2'd3;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [RAD_W-1:0] root;
      logic             frame_end;
   } sqrt_data_type;

   typedef struct packed {
      logic [NUM_W-1:0]  rem;
      logic [DIST_W-1:0] dvs;
      logic [QUO_W-1:0]  quo;
      logic              zero;
      logic              full;
      logic              frame_end;
   } div_data_type;

endpackage

`default_nettype wire

/* src/ckm_if.sv */
// ----------------------------------------------------------------------------
// ckm_if
// Request and response channels of the chroma key mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end_in;

   modport source (output valid, red, green, blue, frame_end_in, input ready);
   modport sink   (input valid, red, green, blue, frame_end_in, output ready);
endinterface

interface ckm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mask_value;
   logic       frame_end_out;

   modport source (output valid, mask_value, frame_end_out, input ready);
   modport sink   (input valid, mask_value, frame_end_out, output ready);
endinterface

`default_nettype wire

/* src/ckm_front.sv */
// ----------------------------------------------------------------------------
// ckm_front
// RGB to Cb/Cr, then squared chroma distance to the key. Two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [1:0]               ce,
   input  wire logic                     vin,
   input  wire logic [7:0]               red,
   input  wire logic [7:0]               green,
   input  wire logic [7:0]               blue,
   input  wire logic                     fe_in,
   input  wire logic [7:0]               key_cb,
   input  wire logic [7:0]               key_cr,
   output logic [1:0]                    valid,
   output logic [ckm_pkg::SQ_W-1:0]      sq,
   output logic                          fe_out
);

   logic [24:0] cb_sum, cr_sum;
   logic [8:0]  cb_ff, cr_ff;
   logic        fe0_ff, fe1_ff;
   logic [1:0]  v_ff;
   logic signed [9:0]  dcb, dcr;
   logic signed [19:0] pcb, pcr;
   logic [ckm_pkg::SQ_W-1:0] sq_in, sq_ff;

   // positive terms always cover the negative ones
   assign cb_sum = 25'(ckm_pkg::CHROMA_OFS_Q16 + ckm_pkg::HALF_Q16)
                 + 25'(ckm_pkg::CB_B_Q16 * 32'(blue))
                 - 25'(ckm_pkg::CB_R_Q16 * 32'(red))
                 - 25'(ckm_pkg::CB_G_Q16 * 32'(green));
   assign cr_sum = 25'(ckm_pkg::CHROMA_OFS_Q16 + ckm_pkg::HALF_Q16)
                 + 25'(ckm_pkg::CR_R_Q16 * 32'(red))
                 - 25'(ckm_pkg::CR_G_Q16 * 32'(green))
                 - 25'(ckm_pkg::CR_B_Q16 * 32'(blue));

   assign dcb = $signed({2'b00, key_cb}) - $signed({1'b0, cb_ff});
   assign dcr = $signed({2'b00, key_cr}) - $signed({1'b0, cr_ff});
   assign pcb = dcb * dcb;
   assign pcr = dcr * dcr;
   assign sq_in = ckm_pkg::SQ_W'(pcb) + ckm_pkg::SQ_W'(pcr);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ce[0]) v_ff[0] <= vin;
         if (ce[1]) v_ff[1] <= v_ff[0];
      end
      if (ce[0]) begin
         cb_ff  <= cb_sum[24:16];
         cr_ff  <= cr_sum[24:16];
         fe0_ff <= fe_in;
      end
      if (ce[1]) begin
         sq_ff  <= sq_in;
         fe1_ff <= fe0_ff;
      end
   end

   assign valid  = v_ff;
   assign sq     = sq_ff;
   assign fe_out = fe1_ff;

endmodule

`default_nettype wire

/* src/ckm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ckm_sqrt_cell
// One digit of the bitwise integer square root; fixed bit weight per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_sqrt_cell #(
   parameter int POS = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ce,
   input  wire logic                   vin,
   input  wire ckm_pkg::sqrt_data_type din,
   output logic                        vout,
   output ckm_pkg::sqrt_data_type      dout
);

   localparam int SHIFT = 2 * (ckm_pkg::SQRT_CELLS - 1 - POS);
   localparam logic [ckm_pkg::RAD_W-1:0] BIT = ckm_pkg::RAD_W'(1) << SHIFT;

   logic [ckm_pkg::RAD_W-1:0] trial;
   ckm_pkg::sqrt_data_type    d_in, d_ff;
   logic                      v_ff;

   assign trial = din.root + BIT;

   always_comb begin
      d_in = din;
      if (din.rad >= trial) begin
         d_in.rad  = din.rad - trial;
         d_in.root = (din.root >> 1) + BIT;
      end else begin
         d_in.root = din.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ce) begin
         v_ff <= vin;
      end
      if (ce) d_ff <= d_in;
   end

   assign vout = v_ff;
   assign dout = d_ff;

endmodule

`default_nettype wire

/* src/ckm_ramp.sv */
// ----------------------------------------------------------------------------
// ckm_ramp
// Compares distance against the tolerances and sets up the ramp division.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_ramp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        ce,
   input  wire logic                        vin,
   input  wire logic [ckm_pkg::DIST_W-1:0]  distance,
   input  wire logic                        fe_in,
   input  wire logic [8:0]                  tol_inner,
   input  wire logic [8:0]                  tol_outer,
   output logic                             vout,
   output ckm_pkg::div_data_type            dout
);

   logic [ckm_pkg::DIST_W-1:0] lo, hi, x;
   ckm_pkg::div_data_type      d_in, d_ff;
   logic                       v_ff;

   assign lo = {tol_inner, 8'd0};
   assign hi = {tol_outer, 8'd0};
   assign x  = distance - lo;

   always_comb begin
      d_in.zero      = distance < lo;
      d_in.full      = !(distance < lo) && (distance >= hi);
      d_in.dvs       = hi - lo;
      // 255 * x, below 255 * dvs so the quotient fits 8 bits
      d_in.rem       = {x, 8'd0} - ckm_pkg::NUM_W'(x);
      d_in.quo       = '0;
      d_in.frame_end = fe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ce) begin
         v_ff <= vin;
      end
      if (ce) d_ff <= d_in;
   end

   assign vout = v_ff;
   assign dout = d_ff;

endmodule

`default_nettype wire

/* src/ckm_div_cell.sv */
// ----------------------------------------------------------------------------
// ckm_div_cell
// One restoring division step, quotient bit POS.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_div_cell #(
   parameter int POS = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  ce,
   input  wire logic                  vin,
   input  wire ckm_pkg::div_data_type din,
   output logic                       vout,
   output ckm_pkg::div_data_type      dout
);

   logic [ckm_pkg::NUM_W-1:0] sdiv;
   ckm_pkg::div_data_type     d_in, d_ff;
   logic                      v_ff;

   assign sdiv = ckm_pkg::NUM_W'(din.dvs) << POS;

   always_comb begin
      d_in = din;
      if (din.rem >= sdiv) begin
         d_in.rem      = din.rem - sdiv;
         d_in.quo[POS] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ce) begin
         v_ff <= vin;
      end
      if (ce) d_ff <= d_in;
   end

   assign vout = v_ff;
   assign dout = d_ff;

endmodule

`default_nettype wire

/* src/ycbcr_chroma_key_mask.sv */
// ----------------------------------------------------------------------------
// ycbcr_chroma_key_mask
// Soft chroma key mask: RGB pixel in, 8-bit key mask out.
// ----------------------------------------------------------------------------
// One RGB request per pixel enters on req; one mask leaves on rsp per request,
// in order, with the frame-end flag carried alongside.
// The datapath is a chain of 28 register stages: two for color conversion and
// squared distance, 17 square root cells (one root bit each), one tolerance
// stage and 8 division cells (one quotient bit each). Throughput is one pixel
// per cycle while rsp.ready stays high.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stalled rsp only backs up the full stages; req.ready
// drops once every stage holds a pixel and rsp.ready is low.
// Registers on the APB port: key_cb 0x0, key_cr 0x4, tol_inner 0x8,
// tol_outer 0xC. Write them only while no pixel is in flight.
// Synchronous reset empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ycbcr_chroma_key_mask (
   input  wire logic        clock,
   input  wire logic        reset,
   ckm_req_if.sink          req,
   ckm_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int NS  = ckm_pkg::SQRT_CELLS;
   localparam int ND  = ckm_pkg::DIV_CELLS;
   localparam int S   = 2 + NS + 1 + ND;
   localparam int SQ0 = 2;
   localparam int RMP = 2 + NS;
   localparam int DV0 = RMP + 1;

   logic [7:0] key_cb_ff, key_cr_ff;
   logic [8:0] tol_inner_ff, tol_outer_ff;
   logic       wr_en;

   // ---------------- register file ----------------
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cb_ff    <= ckm_pkg::KEY_CB_RST;
         key_cr_ff    <= ckm_pkg::KEY_CR_RST;
         tol_inner_ff <= ckm_pkg::TOL_INNER_RST;
         tol_outer_ff <= ckm_pkg::TOL_OUTER_RST;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            ckm_pkg::REG_KEY_CB:    key_cb_ff    <= csr_pwdata[7:0];
            ckm_pkg::REG_KEY_CR:    key_cr_ff    <= csr_pwdata[7:0];
            ckm_pkg::REG_TOL_INNER: tol_inner_ff <= csr_pwdata[8:0];
            ckm_pkg::REG_TOL_OUTER: tol_outer_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ckm_pkg::REG_KEY_CB:    csr_prdata = {24'd0, key_cb_ff};
         ckm_pkg::REG_KEY_CR:    csr_prdata = {24'd0, key_cr_ff};
         ckm_pkg::REG_TOL_INNER: csr_prdata = {23'd0, tol_inner_ff};
         ckm_pkg::REG_TOL_OUTER: csr_prdata = {23'd0, tol_outer_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- stage advance chain ----------------
   logic [S-1:0] v;
   logic [S:0]   ce;

   assign ce[S] = rsp.ready;
   for (genvar i = 0; i < S; i++) begin : g_ce
      assign ce[i] = !v[i] || ce[i+1];
   end

   assign req.ready = ce[0];

   // ---------------- front ----------------
   logic [ckm_pkg::SQ_W-1:0] sq;
   logic                     sq_fe;

   ckm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .ce      (ce[1:0]),
      .vin     (req.valid),
      .red     (req.red),
      .green   (req.green),
      .blue    (req.blue),
      .fe_in   (req.frame_end_in),
      .key_cb  (key_cb_ff),
      .key_cr  (key_cr_ff),
      .valid   (v[1:0]),
      .sq      (sq),
      .fe_out  (sq_fe)
   );

   // ---------------- square root chain ----------------
   ckm_pkg::sqrt_data_type sd [NS+1];

   assign sd[0].rad       = {sq, 16'd0};
   assign sd[0].root      = '0;
   assign sd[0].frame_end = sq_fe;

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      ckm_sqrt_cell #(.POS(i)) u_cell (
         .clock (clock),
         .reset (reset),
         .ce    (ce[SQ0+i]),
         .vin   (v[SQ0+i-1]),
         .din   (sd[i]),
         .vout  (v[SQ0+i]),
         .dout  (sd[i+1])
      );
   end

   // ---------------- ramp setup ----------------
   ckm_pkg::div_data_type dd [ND+1];

   ckm_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce[RMP]),
      .vin       (v[RMP-1]),
      .distance  (sd[NS].root[ckm_pkg::DIST_W-1:0]),
      .fe_in     (sd[NS].frame_end),
      .tol_inner (tol_inner_ff),
      .tol_outer (tol_outer_ff),
      .vout      (v[RMP]),
      .dout      (dd[0])
   );

   // ---------------- division chain, MSB first ----------------
   for (genvar i = 0; i < ND; i++) begin : g_div
      ckm_div_cell #(.POS(ND-1-i)) u_cell (
         .clock (clock),
         .reset (reset),
         .ce    (ce[DV0+i]),
         .vin   (v[DV0+i-1]),
         .din   (dd[i]),
         .vout  (v[DV0+i]),
         .dout  (dd[i+1])
      );
   end

   assign rsp.valid         = v[S-1];
   assign rsp.frame_end_out = dd[ND].frame_end;
   assign rsp.mask_value    = dd[ND].full ? 8'd255 :
                              dd[ND].zero ? 8'd0   : dd[ND].quo;

   // ---------------- assertions ----------------
   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("req.ready low while rsp.ready high");

   a_empty_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp.valid)
      else $error("rsp.valid high right after reset");

   a_no_ramp_binary: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && tol_outer_ff <= tol_inner_ff)
      |-> (rsp.mask_value == 8'd0 || rsp.mask_value == 8'd255))
      else $error("ramp value with outer tolerance not above inner");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chroma key mask: random RGB requests with
// stalls on both channels, predicted masks compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

class mask_scoreboard;
   logic [7:0] key_cb, key_cr;
   logic [8:0] tol_inner, tol_outer;
   logic [7:0] mask_q[$];
   logic       fe_q[$];
   int         errors;

   function new();
      key_cb = ckm_pkg::KEY_CB_RST;
      key_cr = ckm_pkg::KEY_CR_RST;
      tol_inner = ckm_pkg::TOL_INNER_RST;
      tol_outer = ckm_pkg::TOL_OUTER_RST;
      errors = 0;
   endfunction

   function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      longint cb, cr, dcb, dcr, sq, rad, root, bit_v, lo, hi, m;
      cb = (longint'(ckm_pkg::CHROMA_OFS_Q16) + ckm_pkg::CB_B_Q16 * b + ckm_pkg::HALF_Q16
            - ckm_pkg::CB_R_Q16 * r - ckm_pkg::CB_G_Q16 * g) >>> 16;
      cr = (longint'(ckm_pkg::CHROMA_OFS_Q16) + ckm_pkg::CR_R_Q16 * r + ckm_pkg::HALF_Q16
            - ckm_pkg::CR_G_Q16 * g - ckm_pkg::CR_B_Q16 * b) >>> 16;
      dcb = longint'(key_cb) - cb;
      dcr = longint'(key_cr) - cr;
      sq = dcb * dcb + dcr * dcr;
      rad = sq << 16;
      root = 0;
      bit_v = 64'd1 << 40;
      while (bit_v > rad) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (rad >= root + bit_v) begin
            rad = rad - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      lo = longint'(tol_inner) << 8;
      hi = longint'(tol_outer) << 8;
      if (root < lo) m = 0;
      else if (root >= hi) m = 255;
      else begin
         m = (255 * (root - lo)) / (hi - lo);
         if (m > 255) m = 255;
      end
      mask_q.push_back(m[7:0]);
      fe_q.push_back(fe);
   endfunction

   function void check_mask(logic [7:0] mask, logic fe);
      logic [7:0] em;
      logic       ef;
      if (mask_q.size() == 0) begin
         $error("unexpected response: mask_value %0d", mask);
         errors++;
         return;
      end
      em = mask_q.pop_front();
      ef = fe_q.pop_front();
      if (mask !== em) begin
         $error("mask_value expected %0d actual %0d", em, mask);
         errors++;
      end
      if (fe !== ef) begin
         $error("frame_end_out expected %0d actual %0d", ef, fe);
         errors++;
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 28;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          send_idle = 0, recv_idle = 0;
   bit          hold_rsp = 0;
   mask_scoreboard masks = new();

   ckm_req_if req();
   ckm_rsp_if rsp();

   ycbcr_chroma_key_mask u_top (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req.valid = 0; req.red = 0; req.green = 0; req.blue = 0; req.frame_end_in = 0;
      rsp.ready = 0;
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp.valid && rsp.ready) masks.check_mask(rsp.mask_value, rsp.frame_end_out);
      rsp.ready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_idle);
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         ckm_pkg::REG_KEY_CB:    masks.key_cb = value[7:0];
         ckm_pkg::REG_KEY_CR:    masks.key_cr = value[7:0];
         ckm_pkg::REG_TOL_INNER: masks.tol_inner = value[8:0];
         default:                masks.tol_outer = value[8:0];
      endcase
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.red <= r; req.green <= g; req.blue <= b;
      req.frame_end_in <= fe;
      do @(posedge clock); while (!req.ready);
      masks.note_pixel(r, g, b, fe);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (masks.mask_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_pixels(int n);
      logic [7:0] kc;
      repeat (n) begin
         kc = 8'($urandom);
         case ($urandom_range(3))
            0: send_pixel(kc, kc, kc, 1'($urandom_range(1)));   // gray, near default key
            1: send_pixel(8'($urandom_range(40)), 8'($urandom_range(215, 255)),
                          8'($urandom_range(40)), $urandom_range(15) == 0); // green screen
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom_range(1)));
         endcase
      end
   endtask

   task automatic random_config();
      write_reg(ckm_pkg::REG_KEY_CB, $urandom);
      write_reg(ckm_pkg::REG_KEY_CR, $urandom);
      write_reg(ckm_pkg::REG_TOL_INNER, $urandom_range(120));
      write_reg(ckm_pkg::REG_TOL_OUTER, $urandom_range(511));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes and chroma overflow at reset settings
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      drain();
      // no ramp: outer below inner, and equal
      write_reg(ckm_pkg::REG_TOL_INNER, 32'd100);
      write_reg(ckm_pkg::REG_TOL_OUTER, 32'd50);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      drain();
      write_reg(ckm_pkg::REG_TOL_OUTER, 32'd100);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd10, 8'd20, 8'd30, 1'b1);
      drain();
      // extreme register values, wide write data
      write_reg(ckm_pkg::REG_KEY_CB, 32'hFFFF_FF00);
      write_reg(ckm_pkg::REG_KEY_CR, 32'h0000_01FF);
      write_reg(ckm_pkg::REG_TOL_INNER, 32'd0);
      write_reg(ckm_pkg::REG_TOL_OUTER, 32'hFFFF_FFFF);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      drain();
      write_reg(ckm_pkg::REG_TOL_INNER, 32'd511);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      drain();
      write_reg(ckm_pkg::REG_TOL_INNER, 32'd0);
      write_reg(ckm_pkg::REG_TOL_OUTER, 32'd1);
      send_pixel(8'd60, 8'd70, 8'd80, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      drain();

      send_idle = 19; recv_idle = 55;
      random_config();
      random_pixels(300);

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         random_pixels(60);
      join
      drain();

      send_idle = 55; recv_idle = 19;
      random_config();
      random_pixels(300);
      drain();

      send_idle = 0; recv_idle = 0;
      write_reg(ckm_pkg::REG_KEY_CB, 32'd44);
      write_reg(ckm_pkg::REG_KEY_CR, 32'd21);
      write_reg(ckm_pkg::REG_TOL_INNER, 32'd20);
      write_reg(ckm_pkg::REG_TOL_OUTER, 32'd120);
      random_pixels(300);
      drain();
      random_config();
      random_pixels(250);
      drain();

      if (masks.errors == 0 && masks.mask_q.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end
endmodule

`default_nettype wire
